/* rtl/core/nsfe_pkg.sv */
// shared types, character codes and decode functions of the nmea field extractor
package nsfe_pkg;

  localparam int unsigned MAX_FIELD_CHARS = 16;
  localparam int unsigned HEADER_LEN      = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam logic [7:0] HEX_ALPHA_MIN = 8'h40;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;
  localparam logic [7:0] HEX_DIGIT_OFS = 8'h30;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  // type codes: final types and partial header matches
  localparam logic [2:0] TYPE_NONE = 3'd0;
  localparam logic [2:0] TYPE_RMC  = 3'd1;
  localparam logic [2:0] TYPE_GGA  = 3'd2;
  localparam logic [2:0] TYPE_GSA  = 3'd3;
  localparam logic [2:0] TYPE_GSV  = 3'd4;
  localparam logic [2:0] TYPE_P_R  = 3'd5;
  localparam logic [2:0] TYPE_P_G  = 3'd6;
  localparam logic [2:0] TYPE_P_GG = 3'd7;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    PH_BODY   = 2'd0,
    PH_HEX_HI = 2'd1,
    PH_HEX_LO = 2'd2
  } phase_e;

  typedef struct packed {
    logic       in_sentence;
    logic [2:0] header_count;
    logic [2:0] type_code;
    logic [7:0] xor_sum;
    logic [4:0] comma_count;
    logic [4:0] field_char_count;
    phase_e     phase;
    logic [3:0] high_nibble;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [1:0] sentence_type;
    logic [3:0] slot;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic       checksum_ok;
  } result_t;

  function automatic logic [7:0] hex_value(input logic [7:0] b);
    hex_value = (b > HEX_ALPHA_MIN) ? b - HEX_ALPHA_OFS : b - HEX_DIGIT_OFS;
  endfunction

  // header byte n (3, 4 or 5) refines the type match
  function automatic logic [2:0] match_type(input logic [2:0] t, input logic [2:0] n,
                                            input logic [7:0] b);
    logic [2:0] r;
    r = TYPE_NONE;
    if (n == 3'd3) begin
      if (b == CH_R) r = TYPE_P_R;
      else if (b == CH_G) r = TYPE_P_G;
    end else if (n == 3'd4) begin
      if (t == TYPE_P_R && b == CH_M) r = TYPE_P_R;
      else if (t == TYPE_P_G && b == CH_G) r = TYPE_P_GG;
      else if (t == TYPE_P_G && b == CH_S) r = TYPE_P_G;
    end else begin
      if (t == TYPE_P_R && b == CH_C) r = TYPE_RMC;
      else if (t == TYPE_P_GG && b == CH_A) r = TYPE_GGA;
      else if (t == TYPE_P_G && b == CH_A) r = TYPE_GSA;
      else if (t == TYPE_P_G && b == CH_V) r = TYPE_GSV;
    end
    match_type = r;
  endfunction

  // {selected, slot} for a field number of a sentence type
  function automatic logic [4:0] slot_of(input logic [2:0] t, input logic [4:0] c);
    logic [4:0] r;
    r = 5'd0;
    unique case (t)
      TYPE_RMC: if (c >= 5'd1 && c <= 5'd9) r = {1'b1, 4'(c - 5'd1)};
      TYPE_GGA: begin
        if (c == 5'd7) r = {1'b1, 4'd9};
        else if (c == 5'd9) r = {1'b1, 4'd10};
      end
      TYPE_GSA: begin
        if (c == 5'd2) r = {1'b1, 4'd11};
        else if (c == 5'd15) r = {1'b1, 4'd12};
      end
      TYPE_GSV: if (c == 5'd3) r = {1'b1, 4'd13};
      default: r = 5'd0;
    endcase
    slot_of = r;
  endfunction

endpackage

/* rtl/core/nsfe_in_reg.sv */
// input register stage holding one received byte
module nsfe_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  import nsfe_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

/* rtl/core/nsfe_parser.sv */
// sentence state register and per-byte parse logic
module nsfe_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  output nsfe_pkg::result_t    res_o
);
  import nsfe_pkg::*;

  state_t     st_q, st_d;
  result_t    res;
  logic [7:0] hex;
  logic [7:0] rx;
  logic [2:0] hc_next;
  logic [2:0] type_next;
  logic [2:0] type_m1;
  logic [4:0] slot_sel;

  assign hex      = hex_value(byte_i);
  assign rx       = {st_q.high_nibble, 4'd0} + hex;
  assign hc_next  = st_q.header_count + 3'd1;
  assign type_next = match_type(st_q.type_code, hc_next, byte_i);
  assign type_m1  = st_q.type_code - 3'd1;
  assign slot_sel = slot_of(st_q.type_code, st_q.comma_count);

  always_comb begin
    st_d = st_q;
    res  = '0;
    res.sentence_type = type_m1[1:0];
    if (byte_i == CH_DOLLAR) begin
      st_d = '0;
      st_d.phase = PH_BODY;
      st_d.in_sentence = 1'b1;
    end else if (st_q.in_sentence) begin
      if (st_q.phase == PH_HEX_HI) begin
        st_d.high_nibble = hex[3:0];
        st_d.phase       = PH_HEX_LO;
      end else if (st_q.phase == PH_HEX_LO) begin
        res.valid       = 1'b1;
        res.kind        = KIND_VERDICT;
        res.checksum_ok = (rx == st_q.xor_sum);
        st_d.in_sentence = 1'b0;
        st_d.phase       = PH_BODY;
      end else if (byte_i == CH_STAR) begin
        if (st_q.header_count < 3'(HEADER_LEN)) begin
          st_d.in_sentence = 1'b0;
          st_d.phase       = PH_BODY;
        end else begin
          st_d.phase = PH_HEX_HI;
        end
      end else begin
        st_d.xor_sum = st_q.xor_sum ^ byte_i;
        if (st_q.header_count < 3'(HEADER_LEN)) begin
          st_d.header_count = hc_next;
          if (hc_next >= 3'd3) begin
            st_d.type_code = type_next;
            if (type_next == TYPE_NONE) begin
              st_d.in_sentence = 1'b0;
              st_d.phase       = PH_BODY;
            end
          end
        end else if (byte_i == CH_COMMA) begin
          if (st_q.comma_count != COUNT_MAX) st_d.comma_count = st_q.comma_count + 5'd1;
          st_d.field_char_count = 5'd0;
        end else begin
          if (st_q.field_char_count != COUNT_MAX) begin
            st_d.field_char_count = st_q.field_char_count + 5'd1;
          end
          if (slot_sel[4] && ({1'b0, st_q.field_char_count} < 6'(MAX_FIELD_CHARS))) begin
            res.valid      = 1'b1;
            res.kind       = KIND_CHAR;
            res.slot       = slot_sel[3:0];
            res.char_pos   = st_q.field_char_count[3:0];
            res.char_value = byte_i;
          end
        end
      end
    end
    if (!fire_i) begin
      st_d = st_q;
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign res_o = res;

`ifndef ASSERT_OFF
  a_header_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.header_count <= 3'(HEADER_LEN))
    else $error("header count past header length");

  a_dollar_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && byte_i == CH_DOLLAR |=> st_q.in_sentence && st_q.xor_sum == 8'd0)
    else $error("sentence start did not restart state");

  a_verdict_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.kind == KIND_VERDICT |-> st_q.phase == PH_HEX_LO)
    else $error("verdict outside second checksum digit");

  a_type_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.in_sentence && st_q.header_count == 3'(HEADER_LEN) |->
      st_q.type_code == TYPE_RMC || st_q.type_code == TYPE_GGA ||
      st_q.type_code == TYPE_GSA || st_q.type_code == TYPE_GSV)
    else $error("open sentence body without a known type");
`endif

endmodule

/* rtl/core/nsfe_out_reg.sv */
// result register facing the output channel
module nsfe_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nsfe_pkg::result_t res_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nsfe_pkg::result_t res_o
);
  import nsfe_pkg::*;

  logic    valid_q;
  result_t res_q;

  // register frees up when empty or when its transaction completes
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/nmea_sentence_field_extractor_top.sv */
// top level of the nmea sentence field extractor
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | in_byte_i
//  out     | output    | out_valid_o / out_stall_i | kind, type, slot, pos, char, ok
//
// one byte per cycle sustained while the output is not stalled; a result is presented from the result
// register, after its byte has passed the input register and the parse logic
// reset clears the sentence state and both valid flags
// a stalled output holds its result; the input register keeps taking bytes
// while the parse logic can hand its result on, else in_stall_o rises
module nmea_sentence_field_extractor_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic [1:0] out_sentence_type_o,
  output logic [3:0] out_slot_o,
  output logic [3:0] out_char_pos_o,
  output logic [7:0] out_char_value_o,
  output logic       out_checksum_ok_o
);
  import nsfe_pkg::*;

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_q;
  logic       fire;
  result_t    res;
  result_t    res_out;

  assign fire = byte_valid && advance;

  nsfe_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .valid_o    (byte_valid),
    .byte_o     (byte_q)
  );

  nsfe_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .res_o  (res)
  );

  nsfe_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign out_kind_o          = res_out.kind;
  assign out_sentence_type_o = res_out.sentence_type;
  assign out_slot_o          = res_out.slot;
  assign out_char_pos_o      = res_out.char_pos;
  assign out_char_value_o    = res_out.char_value;
  assign out_checksum_ok_o   = res_out.checksum_ok;

`ifndef ASSERT_OFF
  a_char_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_CHAR |-> !out_checksum_ok_o)
    else $error("character item carries a verdict bit");

  a_verdict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_VERDICT |->
      out_slot_o == 4'd0 && out_char_pos_o == 4'd0 && out_char_value_o == 8'd0)
    else $error("verdict item carries character fields");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_CHAR |-> out_slot_o <= 4'd13)
    else $error("slot code out of range");
`endif

endmodule
